[src/prc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg - shared definitions for the pre-trade risk limit check
// Event codes, reject codes, register indexes, table size and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Cancel table size and index width
  localparam int SYMBOLS = 256;
  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // Field and register widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int SYMID_W  = 8;
  localparam int VOL_W    = 32;
  localparam int TOTAL_W  = 40;
  localparam int CNT_W    = 16;
  localparam int REASON_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  // Event codes
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL      = 3'd1;
  localparam logic [OP_W-1:0] OP_STATUS    = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR_FLOW  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLR_TRADE = 3'd5;

  // Reject codes
  localparam logic [REASON_W-1:0] REASON_NONE   = 3'd0;
  localparam logic [REASON_W-1:0] REASON_SIZE   = 3'd1;
  localparam logic [REASON_W-1:0] REASON_TRADED = 3'd2;
  localparam logic [REASON_W-1:0] REASON_FLOW   = 3'd3;
  localparam logic [REASON_W-1:0] REASON_CANCEL = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_ACTIVE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRADE_VOLUME_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_LIMIT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_CLEAR_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL_LIMIT       = 3'd5;

  // Saturation tops
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } prc_state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;   // capture transaction, launch cancel table read
    logic exec;   // evaluate, update state, register result
  } prc_cmd_t;

endpackage

[src/prc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ctrl - transaction sequencer
// Two-state controller: takes a transaction, runs the execute state, then
// raises the result strobe.
// ----------------------------------------------------------------------------
module prc_ctrl
  import prc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output prc_cmd_t cmd
);

  prc_state_t state;
  prc_state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy     = (state != ST_IDLE);
  assign cmd.load = start && (state == ST_IDLE);
  assign cmd.exec = (state == ST_EXEC);

endmodule

[src/prc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_datapath - limit registers, counters and cancel table
// Holds configuration, risk counters and the per-symbol cancel memory;
// evaluates one transaction per execute command.
// ----------------------------------------------------------------------------
module prc_datapath
  import prc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  prc_cmd_t              cmd,
  input  logic [OP_W-1:0]       op,
  input  logic [SYMID_W-1:0]    symbol_id,
  input  logic [VOL_W-1:0]      volume,
  input  logic                  is_cancelled,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  accepted,
  output logic [REASON_W-1:0]   reject_reason
);

  // Configuration
  logic               engine_active;
  logic [VOL_W-1:0]   order_size_limit;
  logic [TOTAL_W-1:0] trade_volume_limit;
  logic [CNT_W-1:0]   flow_limit;
  logic [CNT_W-1:0]   flow_clear_ticks;
  logic [CNT_W-1:0]   cancel_limit;

  // Risk state
  logic [TOTAL_W-1:0] traded_total;
  logic [CNT_W-1:0]   flow_count;
  logic [CNT_W-1:0]   window_timer;

  // Cancel table with per-entry valid bits (unwritten entries read as zero)
  logic [CNT_W-1:0] cancel_mem [SYMBOLS];
  logic [SYMBOLS-1:0] cancel_vld;
  logic [CNT_W-1:0] cancel_rd;
  logic             cancel_rd_vld;

  // Captured transaction
  logic [OP_W-1:0]  op_q;
  logic [SYM_W-1:0] idx_q;
  logic             sym_ok_q;
  logic [VOL_W-1:0] vol_q;
  logic             canc_q;

  logic [SYM_W-1:0] idx_in;
  logic             sym_ok_in;

  assign idx_in    = SYM_W'(symbol_id);
  assign sym_ok_in = (32'(symbol_id) < SYMBOLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_active      <= 1'b0;
      order_size_limit   <= '0;
      trade_volume_limit <= '0;
      flow_limit         <= '0;
      flow_clear_ticks   <= '0;
      cancel_limit       <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENGINE_ACTIVE:      engine_active      <= wr_data[0];
        REG_ORDER_SIZE_LIMIT:   order_size_limit   <= wr_data[VOL_W-1:0];
        REG_TRADE_VOLUME_LIMIT: trade_volume_limit <= wr_data[TOTAL_W-1:0];
        REG_FLOW_LIMIT:         flow_limit         <= wr_data[CNT_W-1:0];
        REG_FLOW_CLEAR_TICKS:   flow_clear_ticks   <= wr_data[CNT_W-1:0];
        REG_CANCEL_LIMIT:       cancel_limit       <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture and table read on load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q          <= op;
      idx_q         <= idx_in;
      sym_ok_q      <= sym_ok_in;
      vol_q         <= volume;
      canc_q        <= is_cancelled;
      cancel_rd     <= cancel_mem[idx_in];
      cancel_rd_vld <= cancel_vld[idx_in];
    end
  end

  // Execute-cycle logic
  logic [CNT_W-1:0]     cancels;
  logic [REASON_W-1:0]  reason;
  logic [TOTAL_W:0]     fill_sum;
  logic [CNT_W-1:0]     timer_inc;
  logic                 cancel_wr;

  logic [TOTAL_W-1:0]   traded_total_next;
  logic [CNT_W-1:0]     flow_count_next;
  logic [CNT_W-1:0]     window_timer_next;

  assign cancels  = (sym_ok_q && cancel_rd_vld) ? cancel_rd : '0;
  assign fill_sum = {1'b0, traded_total} + (TOTAL_W + 1)'(vol_q);
  assign timer_inc = (window_timer != CNT_MAX) ? window_timer + 1'b1 : window_timer;

  always_comb begin
    reason            = REASON_NONE;
    cancel_wr         = 1'b0;
    traded_total_next = traded_total;
    flow_count_next   = flow_count;
    window_timer_next = window_timer;
    case (op_q)
      OP_CHECK: begin
        if (engine_active) begin
          if (order_size_limit != '0 && vol_q > order_size_limit)
            reason = REASON_SIZE;
          else if (trade_volume_limit != '0 && traded_total >= trade_volume_limit)
            reason = REASON_TRADED;
          else if (flow_limit != '0 && flow_count >= flow_limit)
            reason = REASON_FLOW;
          else if (cancel_limit != '0 && cancels >= cancel_limit)
            reason = REASON_CANCEL;
          else if (flow_count != CNT_MAX)
            flow_count_next = flow_count + 1'b1;
        end
      end
      OP_FILL: begin
        traded_total_next = fill_sum[TOTAL_W] ? TOTAL_MAX : fill_sum[TOTAL_W-1:0];
      end
      OP_STATUS: begin
        cancel_wr = canc_q && sym_ok_q && (cancels != CNT_MAX);
      end
      OP_TICK: begin
        if (timer_inc >= flow_clear_ticks) begin
          window_timer_next = '0;
          flow_count_next   = '0;
        end else begin
          window_timer_next = timer_inc;
        end
      end
      OP_CLR_FLOW: begin
        flow_count_next = '0;
      end
      OP_CLR_TRADE: begin
        traded_total_next = '0;
        flow_count_next   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      traded_total <= '0;
      flow_count   <= '0;
      window_timer <= '0;
      cancel_vld   <= '0;
    end else if (cmd.exec) begin
      traded_total <= traded_total_next;
      flow_count   <= flow_count_next;
      window_timer <= window_timer_next;
      if (cancel_wr) cancel_vld[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && cancel_wr) cancel_mem[idx_q] <= cancels + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted      <= (reason == REASON_NONE);
      reject_reason <= reason;
    end
  end

endmodule

[src/pretrade_risk_limit_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pretrade_risk_limit_check - pre-trade risk limit check, top level
// Controller and datapath; one verdict per event transaction.
// ----------------------------------------------------------------------------
// A transaction is taken on a rising edge with start high and busy low; the
// cancel table is read on that same edge. The next cycle, with busy high,
// evaluates the limits and updates the counters; done is high for exactly one
// cycle after that, with accepted and reject_reason valid.
// The receiver cannot stall: the result must be taken on that cycle. busy is
// low again during the done cycle, so a new transaction may start there; no
// new transaction is taken while busy, as the per-symbol cancel memory is
// read into a register ahead of the evaluate step.
// Configuration is written through wr_en / wr_index / wr_data with no wait;
// indexes 6 and 7 are ignored. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pretrade_risk_limit_check
  import prc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // event transaction
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic [SYMID_W-1:0]    symbol_id,
  input  logic [VOL_W-1:0]      volume,
  input  logic                  is_cancelled,
  // verdict, one cycle strobe
  output logic                  done,
  output logic                  accepted,
  output logic [REASON_W-1:0]   reject_reason,
  // configuration writes
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  prc_cmd_t cmd;

  // Sequencer: idle -> execute -> strobe
  prc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Limits, counters, cancel table and verdict registers
  prc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (op),
    .symbol_id     (symbol_id),
    .volume        (volume),
    .is_cancelled  (is_cancelled),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .accepted      (accepted),
    .reject_reason (reject_reason)
  );

`ifndef SYNTHESIS
  // an accepted transaction always occupies the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");

  // the strobe comes directly after an execute cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding execute cycle");

  // a busy cycle is always followed by the strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("execute cycle without result strobe");

  // verdict is consistent with its reason code
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    done |-> (accepted == (reject_reason == REASON_NONE)))
    else $error("accepted and reject_reason disagree");
`endif

endmodule

[dv/tb_pretrade_risk_limit_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pretrade_risk_limit_check - self-checking bench for the risk limit check
// Walks a short table of directed events, then phases of random events under
// different limit settings and sender gaps. Each verdict is checked, oldest
// first, against an in-bench model of the limit book or a typed table entry.
// ----------------------------------------------------------------------------
module tb_pretrade_risk_limit_check;
  import prc_pkg::*;

  // Op codes with no meaning in the block, and register indexes it ignores
  localparam logic [OP_W-1:0]      OP_SPARE6  = 3'd6;
  localparam logic [OP_W-1:0]      OP_SPARE7  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  // Quiet-cycle limit: the longest legal stretch with no transaction is a
  // sender gap on top of the busy cycle, or a register write sequence
  // between phases. The limit leaves ample margin.
  localparam int STALL_LIMIT = 200;

  // Random part: phases of this many events; the saturation phase is longer
  // so that max-size fills can drive the traded total to the top of 40 bits.
  localparam int PHASES       = 8;
  localparam int PHASE_EVENTS = 85;
  localparam int SAT_PHASE    = 6;
  localparam int SAT_EVENTS   = 355;

  typedef struct packed {
    logic                accepted;
    logic [REASON_W-1:0] reason;
  } verdict_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  // One line of the directed table: an event, or a register write. code is
  // the op for an event and the register index for a write.
  typedef struct packed {
    row_kind_t             kind;
    logic [OP_W-1:0]       code;
    logic [SYMID_W-1:0]    sym;
    logic [CFG_DATA_W-1:0] value;
    logic                  canc;
    logic                  typed;
    logic [REASON_W-1:0]   reason;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       op;
  logic [SYMID_W-1:0]    symbol_id;
  logic [VOL_W-1:0]      volume;
  logic                  is_cancelled;
  logic                  done;
  logic                  accepted;
  logic [REASON_W-1:0]   reject_reason;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  // Set alongside a directed transaction whose verdict is typed into the table
  logic                  row_typed;
  logic [REASON_W-1:0]   typed_reason;

  pretrade_risk_limit_check dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .symbol_id    (symbol_id),
    .volume       (volume),
    .is_cancelled (is_cancelled),
    .done         (done),
    .accepted     (accepted),
    .reject_reason(reject_reason),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Limit book model: the limits as last written and the running counters
  // --------------------------------------------------------------------------
  logic                lim_engine;
  logic [VOL_W-1:0]    lim_size;
  logic [TOTAL_W-1:0]  lim_trade;
  logic [CNT_W-1:0]    lim_flow;
  logic [CNT_W-1:0]    lim_ticks;
  logic [CNT_W-1:0]    lim_cancel;

  logic [TOTAL_W-1:0]  book_traded;
  logic [CNT_W-1:0]    book_flow;
  logic [CNT_W-1:0]    book_timer;
  logic [CNT_W-1:0]    book_cancels [SYMBOLS];

  verdict_t            pending_verdicts [$];
  plan_row_t           directed_plan [$];
  int                  mismatch_count = 0;
  int                  verdict_no = 0;
  int                  quiet_cycles = 0;

  // Driver's copy of the order size limit, used to aim volumes at the edge
  logic [VOL_W-1:0]    plan_size;

  // Applies one event to the book and returns the verdict it earns
  function automatic verdict_t risk_verdict(logic [OP_W-1:0] ev_op,
                                            logic [SYMID_W-1:0] sym,
                                            logic [VOL_W-1:0] vol,
                                            logic cxl);
    verdict_t         v;
    logic [TOTAL_W:0] sum;
    logic [CNT_W-1:0] cxl_seen;
    v.reason = REASON_NONE;
    case (ev_op)
      OP_CHECK: begin
        // Inactive engine waves everything through and counts nothing
        if (lim_engine) begin
          // Symbols beyond the table read as no cancels
          cxl_seen = (int'(sym) < SYMBOLS) ? book_cancels[sym] : '0;
          if (lim_size != 0 && vol > lim_size)
            v.reason = REASON_SIZE;
          else if (lim_trade != 0 && book_traded >= lim_trade)
            v.reason = REASON_TRADED;
          else if (lim_flow != 0 && book_flow >= lim_flow)
            v.reason = REASON_FLOW;
          else if (lim_cancel != 0 && cxl_seen >= lim_cancel)
            v.reason = REASON_CANCEL;
          else if (book_flow != CNT_MAX)
            book_flow = book_flow + 1'b1;
        end
      end
      OP_FILL: begin
        sum = {1'b0, book_traded} + (TOTAL_W + 1)'(vol);
        book_traded = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
      OP_STATUS: begin
        if (cxl && int'(sym) < SYMBOLS && book_cancels[sym] != CNT_MAX)
          book_cancels[sym] = book_cancels[sym] + 1'b1;
      end
      OP_TICK: begin
        if (book_timer != CNT_MAX)
          book_timer = book_timer + 1'b1;
        // A clear period of zero clears on every tick
        if (book_timer >= lim_ticks) begin
          book_timer = '0;
          book_flow  = '0;
        end
      end
      OP_CLR_FLOW: book_flow = '0;
      OP_CLR_TRADE: begin
        book_traded = '0;
        book_flow   = '0;
      end
      default: ;
    endcase
    v.accepted = (v.reason == REASON_NONE);
    return v;
  endfunction

  task automatic flag_mismatch(string what, int unsigned seen, int unsigned wanted);
    mismatch_count++;
    $display("mismatch: %s on verdict %0d: got %0d, expected %0d",
             what, verdict_no, seen, wanted);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything here is sampled at the rising edge. The verdict check
  // runs before the new transaction is queued, since a verdict and the next
  // transaction can share an edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst) begin
      lim_engine  = 1'b0;
      lim_size    = '0;
      lim_trade   = '0;
      lim_flow    = '0;
      lim_ticks   = '0;
      lim_cancel  = '0;
      book_traded = '0;
      book_flow   = '0;
      book_timer  = '0;
      for (int s = 0; s < SYMBOLS; s++)
        book_cancels[s] = '0;
    end else begin
      if (done) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("verdict with nothing outstanding", 1, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (accepted !== want.accepted)
            flag_mismatch("accepted", 32'(accepted), 32'(want.accepted));
          if (reject_reason !== want.reason)
            flag_mismatch("reject_reason", 32'(reject_reason), 32'(want.reason));
        end
        verdict_no++;
      end
      if (wr_en) begin
        // Each register keeps only its own width; spare indexes do nothing
        case (wr_index)
          REG_ENGINE_ACTIVE:      lim_engine = wr_data[0];
          REG_ORDER_SIZE_LIMIT:   lim_size   = wr_data[VOL_W-1:0];
          REG_TRADE_VOLUME_LIMIT: lim_trade  = wr_data[TOTAL_W-1:0];
          REG_FLOW_LIMIT:         lim_flow   = wr_data[CNT_W-1:0];
          REG_FLOW_CLEAR_TICKS:   lim_ticks  = wr_data[CNT_W-1:0];
          REG_CANCEL_LIMIT:       lim_cancel = wr_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        // The model runs on every transaction to keep the book in step, even
        // where the table types the verdict in
        want = risk_verdict(op, symbol_id, volume, is_cancelled);
        if (row_typed) begin
          want.accepted = (typed_reason == REASON_NONE);
          want.reason   = typed_reason;
        end
        pending_verdicts.push_back(want);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction moving
  always @(posedge clk) begin
    if ((start && !busy) || done || wr_en || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_pretrade_risk_limit_check: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. Inputs move on the falling edge only. start stays high from one
  // transaction to the next when there is no gap; any gap, register write or
  // the end of stimulus lowers it on the first falling edge after acceptance.
  // --------------------------------------------------------------------------
  task automatic drive_event(logic [OP_W-1:0] ev_op, logic [SYMID_W-1:0] sym,
                             logic [VOL_W-1:0] vol, logic cxl, logic typed,
                             logic [REASON_W-1:0] reason, int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start        <= 1'b1;
    op           <= ev_op;
    symbol_id    <= sym;
    volume       <= vol;
    is_cancelled <= cxl;
    row_typed    <= typed;
    typed_reason <= reason;
    do @(posedge clk); while (busy);
  endtask

  // Register write, only once the block has answered everything. Bits above
  // the register's width are often filled with junk, which must be dropped.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] junk;
    int                    w;
    @(negedge clk) start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    case (idx)
      REG_ENGINE_ACTIVE:      w = 1;
      REG_ORDER_SIZE_LIMIT:   w = VOL_W;
      REG_TRADE_VOLUME_LIMIT: w = TOTAL_W;
      REG_FLOW_LIMIT, REG_FLOW_CLEAR_TICKS, REG_CANCEL_LIMIT: w = CNT_W;
      default:                w = 0;
    endcase
    junk[31:0]  = $urandom;
    junk[39:32] = 8'($urandom_range(255));
    if ($urandom_range(1))
      value = value | (junk << w);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(negedge clk) wr_en <= 1'b0;
  endtask

  task automatic set_limits(logic engine, logic [VOL_W-1:0] size,
                            logic [TOTAL_W-1:0] trade, logic [CNT_W-1:0] flow,
                            logic [CNT_W-1:0] ticks, logic [CNT_W-1:0] cxl_lim);
    logic [CFG_DATA_W-1:0] spare;
    write_reg(REG_ENGINE_ACTIVE, CFG_DATA_W'(engine));
    write_reg(REG_ORDER_SIZE_LIMIT, CFG_DATA_W'(size));
    write_reg(REG_TRADE_VOLUME_LIMIT, trade);
    write_reg(REG_FLOW_LIMIT, CFG_DATA_W'(flow));
    write_reg(REG_FLOW_CLEAR_TICKS, CFG_DATA_W'(ticks));
    write_reg(REG_CANCEL_LIMIT, CFG_DATA_W'(cxl_lim));
    // A write to a spare index must leave every limit alone
    spare[31:0]  = $urandom;
    spare[39:32] = 8'($urandom_range(255));
    write_reg($urandom_range(1) ? REG_SPARE6 : REG_SPARE7, spare);
    plan_size = size;
  endtask

  function automatic logic [VOL_W-1:0] pick_size();
    case ($urandom_range(5))
      0:       return '0;
      1:       return VOL_MAX;
      2:       return $urandom;
      default: return $urandom_range(1, 500);
    endcase
  endfunction

  function automatic logic [TOTAL_W-1:0] pick_trade();
    logic [TOTAL_W-1:0] t;
    t[31:0]  = $urandom;
    t[39:32] = 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return '0;
      1:       return TOTAL_MAX;
      2:       return t;
      default: return TOTAL_W'($urandom_range(1, 20000));
    endcase
  endfunction

  // Counter limits: mostly small so that they bite within a phase
  function automatic logic [CNT_W-1:0] pick_count(int hi);
    case ($urandom_range(5))
      0:       return '0;
      1:       return CNT_MAX;
      default: return CNT_W'($urandom_range(1, hi));
    endcase
  endfunction

  // One random event. fill_heavy phases are mostly max-size fills with no
  // trade clear, to reach saturation of the traded total.
  task automatic random_event(bit fill_heavy, int idle_pct);
    logic [OP_W-1:0]    ev_op;
    logic [SYMID_W-1:0] sym;
    logic [VOL_W-1:0]   vol;
    logic               cxl;
    int                 roll;
    roll = $urandom_range(99);
    if (fill_heavy)
      ev_op = (roll < 80) ? OP_FILL : (roll < 92) ? OP_CHECK :
              (roll < 95) ? OP_STATUS : (roll < 98) ? OP_TICK : OP_CLR_FLOW;
    else
      ev_op = (roll < 45) ? OP_CHECK : (roll < 57) ? OP_FILL :
              (roll < 75) ? OP_STATUS : (roll < 89) ? OP_TICK :
              (roll < 93) ? OP_CLR_FLOW : (roll < 96) ? OP_CLR_TRADE :
              (roll < 98) ? OP_SPARE6 : OP_SPARE7;
    // A handful of hot symbols so cancel counts build up
    sym = ($urandom_range(9) < 7) ? SYMID_W'($urandom_range(7))
                                  : SYMID_W'($urandom_range(255));
    cxl = ($urandom_range(4) != 0);
    if (ev_op == OP_FILL) begin
      if (fill_heavy)
        vol = ($urandom_range(99) < 85) ? VOL_MAX : $urandom;
      else
        vol = ($urandom_range(19) == 0) ? $urandom : $urandom_range(3000);
    end else begin
      // Aim order volumes at and around the size limit
      case ($urandom_range(6))
        0:       vol = '0;
        1:       vol = VOL_MAX;
        2:       vol = plan_size;
        3:       vol = plan_size + 1'b1;
        4:       vol = plan_size - 1'b1;
        5:       vol = $urandom_range(plan_size);
        default: vol = $urandom;
      endcase
    end
    drive_event(ev_op, sym, vol, cxl, 1'b0, REASON_NONE, idle_pct);
  endtask

  function automatic void add_event(logic [OP_W-1:0] ev_op, logic [SYMID_W-1:0] sym,
                                    logic [VOL_W-1:0] vol, logic cxl, logic typed,
                                    logic [REASON_W-1:0] reason);
    plan_row_t r;
    r.kind   = ROW_EVENT;
    r.code   = ev_op;
    r.sym    = sym;
    r.value  = CFG_DATA_W'(vol);
    r.canc   = cxl;
    r.typed  = typed;
    r.reason = reason;
    directed_plan.push_back(r);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.code  = idx;
    r.value = value;
    directed_plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int idle_pct;
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_CHECK;
    symbol_id    = '0;
    volume       = '0;
    is_cancelled = 1'b0;
    wr_en        = 1'b0;
    wr_index     = REG_ENGINE_ACTIVE;
    wr_data      = '0;
    row_typed    = 1'b0;
    typed_reason = REASON_NONE;
    plan_size    = '0;

    // Directed table. Verdicts are typed in where they are plain; the rest
    // come from the model.
    // Out of reset the engine is off: even a huge order passes
    add_event(OP_CHECK,  8'd0,   VOL_MAX, 1'b0, 1'b1, REASON_NONE);
    // Spare ops answer a plain pass and touch nothing
    add_event(OP_SPARE6, 8'd255, VOL_MAX, 1'b1, 1'b1, REASON_NONE);
    add_event(OP_SPARE7, 8'd0,   '0,      1'b0, 1'b1, REASON_NONE);
    add_write(REG_ENGINE_ACTIVE,      1);
    add_write(REG_ORDER_SIZE_LIMIT,   100);
    add_write(REG_TRADE_VOLUME_LIMIT, 1000);
    add_write(REG_FLOW_LIMIT,         2);
    add_write(REG_FLOW_CLEAR_TICKS,   3);
    add_write(REG_CANCEL_LIMIT,       1);
    // Size: one lot over the limit is refused, exactly at it passes
    add_event(OP_CHECK,  8'd0,   101,     1'b0, 1'b1, REASON_SIZE);
    add_event(OP_CHECK,  8'd0,   100,     1'b0, 1'b0, REASON_NONE);
    // Status without cancel counts nothing; with cancel it trips the limit
    add_event(OP_STATUS, 8'd5,   '0,      1'b0, 1'b0, REASON_NONE);
    add_event(OP_STATUS, 8'd5,   '0,      1'b1, 1'b0, REASON_NONE);
    add_event(OP_CHECK,  8'd5,   '0,      1'b0, 1'b1, REASON_CANCEL);
    // Second order fills the flow window, the third is refused on flow
    add_event(OP_CHECK,  8'd255, 1,       1'b0, 1'b0, REASON_NONE);
    add_event(OP_CHECK,  8'd1,   1,       1'b0, 1'b1, REASON_FLOW);
    // Third tick closes the window and frees the flow count
    add_event(OP_TICK,   8'd0,   '0,      1'b0, 1'b0, REASON_NONE);
    add_event(OP_TICK,   8'd0,   '0,      1'b0, 1'b0, REASON_NONE);
    add_event(OP_TICK,   8'd0,   '0,      1'b0, 1'b0, REASON_NONE);
    add_event(OP_CHECK,  8'd1,   1,       1'b0, 1'b0, REASON_NONE);
    add_event(OP_CLR_FLOW, 8'd0, '0,      1'b0, 1'b0, REASON_NONE);
    // One max fill takes the traded total far past its limit
    add_event(OP_FILL,   8'd0,   VOL_MAX, 1'b0, 1'b0, REASON_NONE);
    add_event(OP_CHECK,  8'd1,   1,       1'b0, 1'b1, REASON_TRADED);
    add_event(OP_CLR_TRADE, 8'd0, '0,     1'b0, 1'b0, REASON_NONE);
    add_event(OP_CHECK,  8'd1,   1,       1'b0, 1'b0, REASON_NONE);
    // All limits disabled: a max order on a symbol with cancels passes
    add_write(REG_ORDER_SIZE_LIMIT,   0);
    add_write(REG_TRADE_VOLUME_LIMIT, 0);
    add_write(REG_FLOW_LIMIT,         0);
    add_write(REG_CANCEL_LIMIT,       0);
    add_event(OP_CHECK,  8'd5,   VOL_MAX, 1'b0, 1'b0, REASON_NONE);
    add_event(OP_TICK,   8'd0,   '0,      1'b0, 1'b0, REASON_NONE);

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        write_reg(directed_plan[i].code, directed_plan[i].value);
        if (directed_plan[i].code == REG_ORDER_SIZE_LIMIT)
          plan_size = directed_plan[i].value[VOL_W-1:0];
      end else begin
        drive_event(directed_plan[i].code, directed_plan[i].sym,
                    directed_plan[i].value[VOL_W-1:0], directed_plan[i].canc,
                    directed_plan[i].typed, directed_plan[i].reason, 0);
      end
    end

    // Random phases; sender gaps rotate through none, 66 percent and 36 percent
    // of transactions
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 66;
        default: idle_pct = 36;
      endcase
      case (p)
        0: set_limits(1'b1, '0, '0, '0, '0, '0);
        1: set_limits(1'b0, pick_size(), pick_trade(), pick_count(6), pick_count(12),
                      pick_count(4));
        SAT_PHASE: set_limits(1'b1, VOL_MAX, TOTAL_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
        default: set_limits(1'b1, pick_size(), pick_trade(), pick_count(6),
                            pick_count(12), pick_count(4));
      endcase
      repeat ((p == SAT_PHASE) ? SAT_EVENTS : PHASE_EVENTS)
        random_event(p == SAT_PHASE, idle_pct);
    end

    @(negedge clk) start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // A few more cycles for any stray verdict
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_pretrade_risk_limit_check: clean");
    else
      $display("tb_pretrade_risk_limit_check: errors");
    $finish;
  end

endmodule
